/* src/irpc_pkg.sv */
// Shared types and constants for the pulse-code IR receiver.
package irpc_pkg;

  localparam int unsigned BIT_COUNT_DEF = 7;
  localparam int unsigned CMD_W         = 7;
  localparam int unsigned WIN_W         = 8;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [WIN_W-1:0] START_WINDOW_RST = 8'd157;
  localparam logic [WIN_W-1:0] EDGE_WINDOW_RST  = 8'd75;
  localparam logic [WIN_W-1:0] QUIET_WINDOW_RST = 8'd57;

  localparam logic [CFG_IDX_W-1:0] REG_START_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_EDGE,
    PH_QUIET
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_START,
    ST_BAD_BIT
  } status_e;

endpackage

/* src/ir_pulse_code_receiver.sv */
// Pulse-code IR receiver: per-tick frame decoder with input and result registers.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o   pin_level_i
//   out       output     out_valid_o/out_ready_i status_o, command_o, led_on_o
//   cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One pin sample is taken per cycle while ready is high. A sample is held in the
// input register, the decoder step runs on it, and any result is registered in
// the output register. The decoder step waits only while a result is held unread
// in the output register; the input register then fills and ready drops.
// Reset clears all control state and loads the window registers with defaults.
module ir_pulse_code_receiver #(
  parameter int unsigned BIT_COUNT = irpc_pkg::BIT_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             pin_level_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output irpc_pkg::status_e                status_o,
  output logic [irpc_pkg::CMD_W-1:0]       command_o,
  output logic                             led_on_o,
  input  logic                             cfg_we_i,
  input  logic [irpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [irpc_pkg::WIN_W-1:0]       cfg_data_i
);
  import irpc_pkg::*;

  localparam int unsigned BCW = (BIT_COUNT > 1) ? $clog2(BIT_COUNT) : 1;
  localparam logic [BCW-1:0] LAST_BIT = BCW'(BIT_COUNT - 1);

  // Configuration registers.
  logic [WIN_W-1:0] start_win_q, edge_win_q, quiet_win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_win_q <= START_WINDOW_RST;
      edge_win_q  <= EDGE_WINDOW_RST;
      quiet_win_q <= QUIET_WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_WINDOW: start_win_q <= cfg_data_i;
        REG_EDGE_WINDOW:  edge_win_q  <= cfg_data_i;
        REG_QUIET_WINDOW: quiet_win_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic in_valid_q, pin_q;
  logic step;

  assign step       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pin_q <= pin_level_i;
    end
  end

  // Decoder state.
  phase_e           phase_q, phase_d;
  logic [WIN_W-1:0] tick_q, tick_d;
  logic             high_seen_q, high_seen_d;
  logic             prev_q, prev_d;
  logic [BCW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [CMD_W-1:0] shift_q, shift_d;
  logic             led_q, led_d;

  logic             res_valid;
  status_e          res_status;
  logic [CMD_W-1:0] res_command;

  logic             falling;
  logic [WIN_W-1:0] limit, tick_inc;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    high_seen_d = high_seen_q;
    prev_d      = pin_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    led_d       = led_q;
    res_valid   = 1'b0;
    res_status  = ST_OK;
    res_command = '0;
    falling     = high_seen_q && !pin_q;
    tick_inc    = tick_q + WIN_W'(1);

    unique case (phase_q)
      PH_START: limit = start_win_q;
      PH_EDGE:  limit = edge_win_q;
      PH_QUIET: limit = quiet_win_q;
      default:  limit = start_win_q;
    endcase
    // A zero window takes one sample.
    if (limit == '0) begin
      limit = WIN_W'(1);
    end

    if (phase_q == PH_IDLE) begin
      if (!prev_q && pin_q) begin
        phase_d     = PH_START;
        tick_d      = '0;
        high_seen_d = 1'b0;
      end
    end else if (falling) begin
      if (phase_q == PH_QUIET) begin
        res_valid  = 1'b1;
        res_status = ST_BAD_BIT;
      end else begin
        phase_d     = (phase_q == PH_START) ? PH_EDGE : PH_QUIET;
        tick_d      = '0;
        high_seen_d = 1'b0;
      end
    end else begin
      high_seen_d = pin_q;
      tick_d      = tick_inc;
      if (tick_inc >= limit) begin
        if (phase_q == PH_START) begin
          res_valid  = 1'b1;
          res_status = ST_NO_START;
        end else if (phase_q == PH_EDGE) begin
          res_valid  = 1'b1;
          res_status = ST_BAD_BIT;
        end else begin
          // Quiet window passed: a low last sample reads as a one.
          for (int i = 0; i < CMD_W; i++) begin
            if (!pin_q && (32'(bit_cnt_q) == i)) begin
              shift_d[i] = 1'b1;
            end
          end
          if (bit_cnt_q == LAST_BIT) begin
            res_valid   = 1'b1;
            res_status  = ST_OK;
            res_command = shift_d;
            led_d       = !led_q;
          end else begin
            bit_cnt_d   = bit_cnt_q + BCW'(1);
            phase_d     = PH_EDGE;
            tick_d      = '0;
            high_seen_d = 1'b0;
          end
        end
      end
    end

    if (res_valid) begin
      phase_d     = PH_IDLE;
      tick_d      = '0;
      high_seen_d = 1'b0;
      bit_cnt_d   = '0;
      shift_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      high_seen_q <= 1'b0;
      prev_q      <= 1'b0;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      led_q       <= 1'b0;
    end else if (step) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      high_seen_q <= high_seen_d;
      prev_q      <= prev_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      led_q       <= led_d;
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      status_o  <= res_status;
      command_o <= res_command;
      led_on_o  <= led_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/irpc_checker.sv */
// Port-level checks for the pulse-code IR receiver, bound to the top level.
module irpc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input irpc_pkg::status_e                status_o,
  input logic [irpc_pkg::CMD_W-1:0]       command_o,
  input logic                             led_on_o
);
  import irpc_pkg::*;

  logic out_beat;
  logic led_seen_q;

  assign out_beat = out_valid_o && out_ready_i;

  // LED level carried by the last delivered beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_seen_q <= 1'b0;
    end else if (out_beat) begin
      led_seen_q <= led_on_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(command_o) && $stable(led_on_o))
    else $error("result beat changed while stalled");

  a_abort_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> command_o == '0)
    else $error("abort beat carries a nonzero command");

  a_led_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && status_o == ST_OK |-> led_on_o != led_seen_q)
    else $error("received frame did not toggle the LED level");

  a_led_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && status_o != ST_OK |-> led_on_o == led_seen_q)
    else $error("abort changed the LED level");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

endmodule

bind ir_pulse_code_receiver irpc_checker u_irpc_checker (.*);

/* sim/ir_pulse_code_receiver_test.sv */
// Self-checking testbench for the pulse-code IR receiver: directed frames, faults and random traffic.
`timescale 1ns / 100ps

module ir_pulse_code_receiver_test;
  import irpc_pkg::*;

  localparam int unsigned FRAME_BITS     = BIT_COUNT_DEF;
  localparam int unsigned MAX_IDLE       = 14;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_SAMPLES = 150;
  localparam int unsigned EDGE_SPAN_MAX  = 8;

  localparam logic [WIN_W-1:0]     WIN_MAX    = 8'hFF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    status_e          status;
    logic [CMD_W-1:0] command;
    logic             led_on;
  } frame_result_t;

  typedef enum logic [1:0] {
    FAULT_NO_START,
    FAULT_EDGE_LATE,
    FAULT_QUIET_FALL,
    FAULT_NOISE
  } fault_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 pin_level_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  status_e              status_o;
  logic [CMD_W-1:0]     command_o;
  logic                 led_on_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WIN_W-1:0]     cfg_data_i  = '0;

  // Decoder copy: window settings and frame state as the block should hold them.
  logic [WIN_W-1:0] start_ticks  = START_WINDOW_RST;
  logic [WIN_W-1:0] edge_ticks   = EDGE_WINDOW_RST;
  logic [WIN_W-1:0] quiet_ticks  = QUIET_WINDOW_RST;
  phase_e           frame_phase  = PH_IDLE;
  logic [WIN_W-1:0] window_ticks = '0;
  logic             window_high  = 1'b0;
  logic             last_pin     = 1'b0;
  int unsigned      bits_taken   = 0;
  logic [CMD_W-1:0] cmd_bits     = '0;
  logic             led_level    = 1'b0;

  frame_result_t pending_frames[$];
  int unsigned   mismatch_count   = 0;
  int unsigned   samples_sent     = 0;
  bit            tx_idle_on       = 1'b1;
  bit            rx_idle_on       = 1'b1;

  ir_pulse_code_receiver #(
    .BIT_COUNT(FRAME_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pin_level_i(pin_level_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .command_o  (command_o),
    .led_on_o   (led_on_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned span_of(input logic [WIN_W-1:0] ticks);
    return (ticks == '0) ? 1 : int'(ticks);
  endfunction

  function automatic void open_window(input phase_e to_phase);
    frame_phase  = to_phase;
    window_ticks = '0;
    window_high  = 1'b0;
  endfunction

  function automatic bit close_frame(input status_e status, input logic [CMD_W-1:0] command,
                                     output frame_result_t res);
    res.status  = status;
    res.command = command;
    res.led_on  = led_level;
    open_window(PH_IDLE);
    bits_taken = 0;
    cmd_bits   = '0;
    return 1'b1;
  endfunction

  // Advances the decoder by one pin sample; returns 1 when the sample ends a frame.
  function automatic bit decode_tick(input logic pin, output frame_result_t res);
    logic             prev;
    logic [WIN_W-1:0] limit;
    prev        = last_pin;
    last_pin    = pin;
    res.status  = ST_OK;
    res.command = '0;
    res.led_on  = 1'b0;
    if (frame_phase == PH_IDLE) begin
      if (!prev && pin) open_window(PH_START);
      return 1'b0;
    end
    case (frame_phase)
      PH_START: limit = start_ticks;
      PH_EDGE:  limit = edge_ticks;
      default:  limit = quiet_ticks;
    endcase
    if (limit == '0) limit = WIN_W'(1);
    // A falling edge needs a high sample earlier in the same window.
    if (window_high && !pin) begin
      if (frame_phase == PH_QUIET) return close_frame(ST_BAD_BIT, '0, res);
      open_window(frame_phase == PH_START ? PH_EDGE : PH_QUIET);
      return 1'b0;
    end
    window_high  = pin;
    window_ticks = window_ticks + 1'b1;
    if (window_ticks < limit) return 1'b0;
    if (frame_phase == PH_START) return close_frame(ST_NO_START, '0, res);
    if (frame_phase == PH_EDGE) return close_frame(ST_BAD_BIT, '0, res);
    // The quiet window ran out: a low last sample means a one.
    if (!pin && bits_taken < CMD_W) cmd_bits[bits_taken] = 1'b1;
    bits_taken++;
    if (bits_taken >= FRAME_BITS) begin
      led_level = ~led_level;
      return close_frame(ST_OK, cmd_bits, res);
    end
    open_window(PH_EDGE);
    return 1'b0;
  endfunction

  function automatic logic [WIN_W-1:0] draw_window(input int unsigned floor_ticks);
    case ($urandom_range(0, 7))
      0:       return WIN_W'($urandom_range(0, 1));
      1:       return WIN_W'($urandom_range(12, 40));
      default: return WIN_W'($urandom_range(floor_ticks, 8));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic pin);
    int unsigned   gap;
    frame_result_t res;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pin_level_i <= pin;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    samples_sent++;
    if (decode_tick(pin, res)) begin
      pending_frames.push_back(res);
    end
  endtask

  task automatic wait_drained();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_windows(input logic [WIN_W-1:0] start_w, input logic [WIN_W-1:0] edge_w,
                               input logic [WIN_W-1:0] quiet_w, input bit poke_unused);
    logic [WIN_W-1:0] junk;
    junk = WIN_W'($urandom_range(0, 255));
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_START_WINDOW;
    cfg_data_i  <= start_w;
    @(posedge clk_i);
    start_ticks = start_w;
    cfg_index_i <= REG_EDGE_WINDOW;
    cfg_data_i  <= edge_w;
    @(posedge clk_i);
    edge_ticks = edge_w;
    cfg_index_i <= REG_QUIET_WINDOW;
    cfg_data_i  <= quiet_w;
    @(posedge clk_i);
    quiet_ticks = quiet_w;
    if (poke_unused) begin
      // Nothing lives at this index, so the decoder must not change.
      cfg_index_i <= REG_UNUSED;
      cfg_data_i  <= junk;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Some lows, some highs, then the falling edge, all early inside the window.
  task automatic send_edge_window(input int unsigned span);
    int unsigned highs, lows, used;
    used  = (span > EDGE_SPAN_MAX) ? EDGE_SPAN_MAX : span;
    highs = (used > 1) ? $urandom_range(1, used - 1) : 1;
    lows  = (used - 1 > highs) ? $urandom_range(0, used - 1 - highs) : 0;
    repeat (lows) send_sample(1'b0);
    repeat (highs) send_sample(1'b1);
    send_sample(1'b0);
  endtask

  // A window with no falling edge: lows then highs, ending low when asked.
  task automatic send_steady_window(input logic ends_low, input int unsigned span);
    int unsigned lows;
    lows = ends_low ? span : $urandom_range(0, span - 1);
    repeat (lows) send_sample(1'b0);
    repeat (span - lows) send_sample(1'b1);
  endtask

  task automatic flush_to_idle();
    while (frame_phase != PH_IDLE) send_sample(1'b0);
  endtask

  task automatic send_frame(input logic [CMD_W-1:0] command);
    flush_to_idle();
    send_sample(1'b0);
    send_sample(1'b1);
    send_edge_window(span_of(start_ticks));
    for (int i = 0; i < FRAME_BITS; i++) begin
      send_edge_window(span_of(edge_ticks));
      send_steady_window(command[i], span_of(quiet_ticks));
    end
  endtask

  task automatic send_faulty_frame(input fault_e fault);
    int unsigned good_bits;
    flush_to_idle();
    if (fault == FAULT_NOISE) begin
      repeat ($urandom_range(4, 40)) send_sample(1'($urandom_range(0, 1)));
      return;
    end
    send_sample(1'b0);
    send_sample(1'b1);
    if (fault == FAULT_NO_START) begin
      send_steady_window(1'($urandom_range(0, 1)), span_of(start_ticks));
      return;
    end
    send_edge_window(span_of(start_ticks));
    good_bits = $urandom_range(0, FRAME_BITS - 1);
    repeat (good_bits) begin
      send_edge_window(span_of(edge_ticks));
      send_steady_window(1'($urandom_range(0, 1)), span_of(quiet_ticks));
    end
    if (fault == FAULT_EDGE_LATE) begin
      send_steady_window(1'($urandom_range(0, 1)), span_of(edge_ticks));
    end else begin
      send_edge_window(span_of(edge_ticks));
      repeat ($urandom_range(0, span_of(quiet_ticks) >= 2 ? span_of(quiet_ticks) - 2 : 0))
        send_sample(1'b0);
      send_sample(1'b1);
      send_sample(1'b0);
    end
  endtask

  // A pin already high on the first sample after reset counts as a rising edge.
  // The start edge follows at once, and the default edge window then runs out.
  task automatic test_power_up_trigger();
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    flush_to_idle();
  endtask

  task automatic test_default_frame();
    send_frame(7'h5A);
  endtask

  task automatic test_window_limits();
    // A zero window acts as a single sample, so the start can never succeed.
    write_windows('0, '0, '0, 1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    write_windows(8'd1, 8'd1, 8'd1, 1'b0);
    send_frame(7'h55);
    // Shortest frames that can pass: one-sample quiet windows.
    write_windows(8'd2, 8'd2, 8'd1, 1'b0);
    send_frame(CMD_W'((1 << CMD_W) - 1));
    send_frame('0);
    write_windows(WIN_MAX, 8'd2, 8'd2, 1'b0);
    tx_idle_on = 1'b0;
    flush_to_idle();
    send_sample(1'b0);
    send_sample(1'b1);
    // The start edge lands on the last sample of the widest window.
    repeat (WIN_MAX - 1) send_sample(1'b1);
    send_sample(1'b0);
    flush_to_idle();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_faults();
    write_windows(8'd4, 8'd5, 8'd3, 1'b0);
    send_faulty_frame(FAULT_QUIET_FALL);
    send_faulty_frame(FAULT_EDGE_LATE);
    send_faulty_frame(FAULT_NO_START);
    send_faulty_frame(FAULT_NOISE);
    send_frame(7'h33);
  endtask

  task automatic test_random_frames();
    int unsigned first_sample;
    first_sample = samples_sent;
    while (samples_sent - first_sample < RANDOM_SAMPLES) begin
      write_windows(draw_window(2), draw_window(2), draw_window(1), 1'b0);
      repeat ($urandom_range(1, 3)) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) != 0) begin
          send_frame(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)));
        end else begin
          case ($urandom_range(0, 3))
            0:       send_faulty_frame(FAULT_NO_START);
            1:       send_faulty_frame(FAULT_EDGE_LATE);
            2:       send_faulty_frame(FAULT_QUIET_FALL);
            default: send_faulty_frame(FAULT_NOISE);
          endcase
        end
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_power_up_trigger();
    test_default_frame();
    test_window_limits();
    test_faults();
    test_random_frames();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Each result beat is matched against the oldest frame still expected.
  initial begin : result_checker
    int unsigned   stall;
    frame_result_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (status %0d)", status_o));
      end else begin
        want = pending_frames.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (command_o !== want.command)
          report_mismatch($sformatf("command 0x%0h, expected 0x%0h", command_o, want.command));
        if (led_on_o !== want.led_on)
          report_mismatch($sformatf("led_on %0b, expected %0b", led_on_o, want.led_on));
      end
    end
  end

  initial begin : watchdog
    int unsigned stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni !== 1'b1 || (in_valid_i && in_ready_o === 1'b1) ||
          (out_valid_o === 1'b1 && out_ready_i))
        stalled_cycles = 0;
      else
        stalled_cycles++;
    end
    $display("%0t timeout: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
